>>> rtl/mvna_pkg.sv
package mvna_pkg;

	localparam int VERTEX_DEPTH_DEF = 1024;
	localparam int COORD_BITS_DEF   = 16;
	localparam int SUM_BITS         = 48;
	localparam int IDX_BITS         = 10;
	localparam int CNT_BITS         = 11;
	localparam int CFG_IDX_BITS     = 1;
	localparam int CFG_DATA_BITS    = 11;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_INDEXED_MODE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_COUNT = 1'd1;

	// item kinds
	localparam logic [1:0] KIND_WRITE    = 2'd0;
	localparam logic [1:0] KIND_TRIANGLE = 2'd1;
	localparam logic [1:0] KIND_READ     = 2'd2;
	localparam logic [1:0] KIND_UNUSED   = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [IDX_BITS-1:0] index_a;
		logic [IDX_BITS-1:0] index_b;
		logic [IDX_BITS-1:0] index_c;
		logic signed [15:0]  coord_x;
		logic signed [15:0]  coord_y;
		logic signed [15:0]  coord_z;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               zero_length;
		logic               bad_index;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_VRD,
		ST_VLAT,
		ST_CROSS,
		ST_ARD,
		ST_ALAT,
		ST_AWR,
		ST_RRD,
		ST_RLAT,
		ST_MAG,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

>>> rtl/mesh_vertex_normal_accumulator.sv
// Path to done: a vertex write, bad index or unused kind goes from check to done; a triangle
//   reads corners, forms the cross product and adds it into each corner; a read normalises
//   (zero vectors end at the shift step). One item at a time; busy falls the cycle after done.
// One saturating adder and one 32x32 multiplier under a sequencer, with a bit-serial square
//   root (32 steps) and divider (3 x 17 steps). The receiver cannot stall: done lasts one cycle.
// Reset: asynchronous, active low; sequencer and config reset, memories undefined until written.
module mesh_vertex_normal_accumulator #(
	parameter int VERTEX_DEPTH = mvna_pkg::VERTEX_DEPTH_DEF,
	parameter int COORD_BITS   = mvna_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  mvna_pkg::in_word_t                  item,
	output logic                                done,
	output mvna_pkg::out_word_t                 result,
	input  logic                                cfg_we,
	input  logic [mvna_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mvna_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import mvna_pkg::*;

	localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
	localparam int CB = COORD_BITS;
	localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
	localparam logic [16:0] DEPTH_W = 17'(VERTEX_DEPTH);

	// configuration
	logic                indexed_q;
	logic [CNT_BITS-1:0] vcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indexed_q <= 1'b1;
			vcount_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INDEXED_MODE: indexed_q <= cfg_data[0];
				REG_VERTEX_COUNT: vcount_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// memories
	logic [3*CB-1:0]       vmem [VERTEX_DEPTH];
	logic [3*SUM_BITS-1:0] smem [VERTEX_DEPTH];
	logic [3*CB-1:0]       vrd_q;
	logic [3*SUM_BITS-1:0] srd_q;
	logic [AW-1:0]         raddr, waddr;
	logic                  vwe, swe;
	logic [3*CB-1:0]       vwd;
	logic [3*SUM_BITS-1:0] swd;

	always_ff @(posedge clk) begin
		if (vwe) vmem[waddr] <= vwd;
		vrd_q <= vmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (swe) smem[waddr] <= swd;
		srd_q <= smem[raddr];
	end

	// sequencer registers
	state_t                state_q, state_d;
	in_word_t              item_q;
	logic [16:0]           c_q [3];
	logic [1:0]            k_q;
	logic signed [CB:0]    u_q [3];
	logic signed [CB:0]    w_q [3];
	logic signed [CB-1:0]  p_q [3];
	logic [SUM_BITS-1:0]   n_q [3];
	logic [SUM_BITS-1:0]   s_q [3];
	logic [SUM_BITS-1:0]   m_q [3];
	logic [5:0]            step_q;
	logic [63:0]           rem_q, root_q, sq_q;
	logic [31:0]           len_q;
	logic [47:0]           dr_q;
	logic [16:0]           quo_q;
	logic [15:0]           res_q [3];
	logic                  bad_q, zero_q;

	// index checks
	logic [16:0] ia_w, c0, c1, c2;
	logic        bad_c;
	function automatic logic ok(input logic [16:0] i, input logic [CNT_BITS-1:0] n);
		ok = (i < 17'(n)) && (i < DEPTH_W);
	endfunction

	always_comb begin
		ia_w = 17'(item_q.index_a);
		if (item_q.kind == KIND_TRIANGLE && !indexed_q) begin
			c0 = 17'(ia_w * 17'd3);
			c1 = 17'(c0 + 17'd1);
			c2 = 17'(c0 + 17'd2);
		end else begin
			c0 = ia_w;
			c1 = 17'(item_q.index_b);
			c2 = 17'(item_q.index_c);
		end
		case (item_q.kind)
			KIND_WRITE, KIND_READ: bad_c = !ok(c0, vcount_q);
			KIND_TRIANGLE:         bad_c = !(ok(c0, vcount_q) && ok(c1, vcount_q)
						&& ok(c2, vcount_q));
			default:               bad_c = 1'b0;
		endcase
	end

	// shared 32x32 multiplier, operands chosen by state and step
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	assign mul_p = mul_a * mul_b;

	// saturating accumulate, one lane per step
	logic [SUM_BITS-1:0] add_a, add_b, add_s;
	logic                add_ovf;
	logic [1:0]          lane;
	always_comb begin
		lane    = (step_q[1:0] == 2'd3) ? 2'd0 : step_q[1:0];
		add_a   = s_q[lane];
		add_b   = n_q[lane];
		add_s   = add_a + add_b;
		add_ovf = (add_a[SUM_BITS-1] == add_b[SUM_BITS-1]) &&
			(add_s[SUM_BITS-1] != add_a[SUM_BITS-1]);
		if (add_ovf) add_s = add_a[SUM_BITS-1] ? SUM_MIN : SUM_MAX;
	end

	// max magnitude and sqrt / divider steps
	logic [SUM_BITS-1:0] mmax;
	logic [63:0]         sq_try;
	logic [48:0]         dv_try;
	logic [17:0]         q_inc;
	logic [15:0]         q_clip;
	always_comb begin
		mmax = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
		if (m_q[2] > mmax) mmax = m_q[2];
		sq_try = root_q | (64'd1 << (7'd62 - {step_q, 1'b0}));
		dv_try = {1'b0, dr_q} - {17'd0, len_q};
		// round half up from the 17-bit quotient, then clip
		q_inc  = 18'(quo_q) + 18'd1;
		q_clip = (q_inc[17:1] > 17'd32767) ? 16'd32767 : q_inc[16:1];
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_CROSS) begin
			// products for the three components in step pairs
			case (step_q[2:0])
				3'd0: begin mul_a = 33'(u_q[1]); mul_b = 33'(w_q[2]); end
				3'd1: begin mul_a = 33'(u_q[2]); mul_b = 33'(w_q[1]); end
				3'd2: begin mul_a = 33'(u_q[2]); mul_b = 33'(w_q[0]); end
				3'd3: begin mul_a = 33'(u_q[0]); mul_b = 33'(w_q[2]); end
				3'd4: begin mul_a = 33'(u_q[0]); mul_b = 33'(w_q[1]); end
				default: begin mul_a = 33'(u_q[1]); mul_b = 33'(w_q[0]); end
			endcase
		end else if (state_q == ST_SQ) begin
			mul_a = 33'(m_q[step_q[1:0]][31:0]);
			mul_b = 33'(m_q[step_q[1:0]][31:0]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_CHECK;
			ST_CHECK: begin
				if (bad_c || item_q.kind == KIND_UNUSED || item_q.kind == KIND_WRITE)
					state_d = ST_DONE;
				else if (item_q.kind == KIND_TRIANGLE) state_d = ST_VRD;
				else state_d = ST_RRD;
			end
			ST_VRD:   state_d = ST_VLAT;
			ST_VLAT:  state_d = (k_q == 2'd2) ? ST_CROSS : ST_VRD;
			ST_CROSS: if (step_q == 6'd6) state_d = ST_ARD;
			ST_ARD:   state_d = ST_ALAT;
			ST_ALAT:  state_d = ST_AWR;
			ST_AWR:   if (step_q == 6'd3) state_d = (k_q == 2'd2) ? ST_DONE : ST_ARD;
			ST_RRD:   state_d = ST_RLAT;
			ST_RLAT:  state_d = ST_MAG;
			ST_MAG:   state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (mmax == '0) state_d = ST_DONE;
				else if (mmax < (48'd1 << 30)) state_d = ST_SQ;
			end
			ST_SQ:    if (step_q == 6'd2) state_d = ST_SQRT;
			ST_SQRT:  if (step_q == 6'd31) state_d = ST_DIV;
			ST_DIV:   if (step_q == 6'd18 && k_q == 2'd2) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		raddr = '0;
		waddr = AW'(c_q[0]);
		vwe   = 1'b0;
		swe   = 1'b0;
		vwd   = {CB'($unsigned(item_q.coord_x)), CB'($unsigned(item_q.coord_y)),
			CB'($unsigned(item_q.coord_z))};
		swd   = '0;
		case (state_q)
			ST_CHECK: begin
				waddr = AW'(c0);
				vwe   = item_q.kind == KIND_WRITE && !bad_c;
				swe   = vwe;
			end
			ST_VRD:  raddr = AW'(c_q[k_q]);
			ST_ARD:  raddr = AW'(c_q[k_q]);
			ST_RRD:  raddr = AW'(c_q[0]);
			ST_AWR: begin
				waddr = AW'(c_q[k_q]);
				swe   = step_q == 6'd3;
				swd   = {s_q[0], s_q[1], s_q[2]};
			end
			default: ;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= item;
				k_q    <= '0;
				step_q <= '0;
				bad_q  <= 1'b0;
				zero_q <= 1'b0;
				for (int i = 0; i < 3; i++) res_q[i] <= '0;
			end
			ST_CHECK: begin
				c_q[0] <= c0;
				c_q[1] <= c1;
				c_q[2] <= c2;
				bad_q  <= bad_c;
			end
			ST_VLAT: begin
				// fold corner coordinates into edge vectors
				for (int i = 0; i < 3; i++) begin
					p_q[i] <= vrd_q[(2-i)*CB +: CB];
					if (k_q == 2'd1) u_q[i] <= (CB+1)'(p_q[i]) -
						(CB+1)'($signed(vrd_q[(2-i)*CB +: CB]));
					if (k_q == 2'd2) w_q[i] <= (CB+1)'(p_q[i]) -
						(CB+1)'($signed(vrd_q[(2-i)*CB +: CB]));
				end
				k_q <= k_q + 2'd1;
			end
			ST_CROSS: begin
				if (step_q < 6'd6) begin
					if (!step_q[0]) n_q[step_q[2:1]] <= SUM_BITS'(mul_p);
					else n_q[step_q[2:1]] <= n_q[step_q[2:1]] - SUM_BITS'(mul_p);
				end
				step_q <= step_q + 6'd1;
				k_q    <= '0;
			end
			ST_ALAT: begin
				s_q[0] <= srd_q[3*SUM_BITS-1 -: SUM_BITS];
				s_q[1] <= srd_q[2*SUM_BITS-1 -: SUM_BITS];
				s_q[2] <= srd_q[SUM_BITS-1 -: SUM_BITS];
				step_q <= '0;
			end
			ST_AWR: begin
				// add one lane per cycle, then write the corner back
				if (step_q < 6'd3) begin
					s_q[lane] <= add_s;
					step_q    <= step_q + 6'd1;
				end else begin
					k_q    <= k_q + 2'd1;
					step_q <= '0;
				end
			end
			ST_RLAT: begin
				s_q[0] <= srd_q[3*SUM_BITS-1 -: SUM_BITS];
				s_q[1] <= srd_q[2*SUM_BITS-1 -: SUM_BITS];
				s_q[2] <= srd_q[SUM_BITS-1 -: SUM_BITS];
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++)
					m_q[i] <= s_q[i][SUM_BITS-1] ? -s_q[i] : s_q[i];
			end
			ST_SHIFT: begin
				if (mmax == '0) zero_q <= 1'b1;
				else if (mmax >= (48'd1 << 30))
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				step_q <= '0;
				sq_q   <= '0;
			end
			ST_SQ: begin
				sq_q   <= sq_q + 64'(mul_p);
				step_q <= (step_q == 6'd2) ? 6'd0 : step_q + 6'd1;
				rem_q  <= sq_q + 64'(mul_p);
				root_q <= '0;
			end
			ST_SQRT: begin
				// one result bit per cycle
				if (rem_q >= sq_try) begin
					rem_q  <= rem_q - sq_try;
					root_q <= (root_q >> 1) | (64'd1 << (7'd62 - {step_q, 1'b0}));
				end else begin
					root_q <= root_q >> 1;
				end
				step_q <= (step_q == 6'd31) ? 6'd0 : step_q + 6'd1;
				if (step_q == 6'd31) k_q <= '0;
			end
			ST_DIV: begin
				// restoring divide of m*65536 by L, 17 quotient bits, then rounded
				if (step_q == 6'd0) begin
					len_q  <= (root_q[31:0] == '0) ? 32'd1 : root_q[31:0];
					dr_q   <= 48'(m_q[k_q][30:0]);
					quo_q  <= '0;
					step_q <= 6'd1;
				end else if (step_q <= 6'd17) begin
					if (dv_try[48] == 1'b0) begin
						dr_q  <= {dv_try[46:0], 1'b0};
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						dr_q  <= {dr_q[46:0], 1'b0};
						quo_q <= {quo_q[15:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
				end else begin
					res_q[k_q] <= s_q[k_q][SUM_BITS-1] ? -q_clip : q_clip;
					k_q    <= k_q + 2'd1;
					step_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;
	assign result = '{normal_x: res_q[0], normal_y: res_q[1], normal_z: res_q[2],
		zero_length: zero_q & ~bad_q, bad_index: bad_q};

	a_busy_until_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.bad_index && result.zero_length)) else $error("flags");
endmodule
